>>> src/tecs_pkg.sv
// Package for the tablet event calibrate/scale block: widths, event codes,
// register indexes, state enums and the structs passed between modules.
// No dependencies.
`default_nettype none

package tecs_pkg;

  // Stored coordinate width (legal range 8..32).
  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned TypeWidth   = 16;
  localparam int unsigned CodeWidth   = 16;
  localparam int unsigned SizeWidth   = 16;
  localparam int unsigned BtnWidth    = 3;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned RangeWidth  = CoordWidth + 1;
  localparam int unsigned ProdWidth   = CoordWidth + SizeWidth;
  localparam int unsigned DivCntWidth = $clog2(SizeWidth);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [RangeWidth-1:0] span_t;
  typedef logic [SizeWidth-1:0]         size_t;
  typedef logic [BtnWidth-1:0]          btn_t;

  // Event types and codes (evdev numbering)
  localparam logic [TypeWidth-1:0] EvtSyn     = TypeWidth'(0);
  localparam logic [TypeWidth-1:0] EvtKey     = TypeWidth'(1);
  localparam logic [TypeWidth-1:0] EvtAbs     = TypeWidth'(3);
  localparam logic [CodeWidth-1:0] AxisX      = CodeWidth'(0);
  localparam logic [CodeWidth-1:0] AxisY      = CodeWidth'(1);
  localparam logic [CodeWidth-1:0] KeyLeft    = CodeWidth'(16'h110);
  localparam logic [CodeWidth-1:0] KeyRight   = CodeWidth'(16'h111);
  localparam logic [CodeWidth-1:0] KeyMiddle  = CodeWidth'(16'h112);
  localparam logic [CodeWidth-1:0] SyncReport = CodeWidth'(0);

  localparam btn_t BtnLeft   = BtnWidth'(1);
  localparam btn_t BtnRight  = BtnWidth'(2);
  localparam btn_t BtnMiddle = BtnWidth'(4);

  localparam logic ReqEvent = 1'b0;
  localparam logic ReqRead  = 1'b1;

  localparam logic [CfgIdxWidth-1:0] CfgScreenWidth  = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] CfgScreenHeight = CfgIdxWidth'(1);

  localparam size_t ResetScreenWidth  = SizeWidth'(1024);
  localparam size_t ResetScreenHeight = SizeWidth'(768);

  typedef enum logic [2:0] {
    SeqIdle,
    SeqXStart,
    SeqXWait,
    SeqYStart,
    SeqYWait,
    SeqPush
  } seq_state_e;

  typedef enum logic [2:0] {
    ScIdle,
    ScRange,
    ScOffset,
    ScMul,
    ScDiv,
    ScDone
  } scale_state_e;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    btn_t   pressed;
    logic   pending;
  } trk_state_t;

  typedef struct packed {
    coord_t pos;
    coord_t lo;
    coord_t hi;
    size_t  size;
  } scale_req_t;

  typedef struct packed {
    logic                         frame_ready;
    logic signed [ValueWidth-1:0] raw_x;
    logic signed [ValueWidth-1:0] raw_y;
    size_t                        scaled_x;
    size_t                        scaled_y;
    btn_t                         button_bits;
  } result_t;

endpackage

`default_nettype wire

>>> src/tecs_if.sv
// Channel interfaces: event/read request words, result words, config writes.
// Depends on tecs_pkg.
`default_nettype none

interface tecs_evt_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic [tecs_pkg::TypeWidth-1:0]        ev_type;
  logic [tecs_pkg::CodeWidth-1:0]        ev_code;
  logic signed [tecs_pkg::ValueWidth-1:0] ev_value;

  modport source (output valid, req_type, ev_type, ev_code, ev_value, input ready);
  modport sink   (input valid, req_type, ev_type, ev_code, ev_value, output ready);
endinterface

interface tecs_res_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  frame_ready;
  logic signed [tecs_pkg::ValueWidth-1:0] raw_x;
  logic signed [tecs_pkg::ValueWidth-1:0] raw_y;
  logic [tecs_pkg::SizeWidth-1:0]        scaled_x;
  logic [tecs_pkg::SizeWidth-1:0]        scaled_y;
  logic [tecs_pkg::BtnWidth-1:0]         button_bits;

  modport source (output valid, frame_ready, raw_x, raw_y, scaled_x, scaled_y, button_bits,
                  input ready);
  modport sink   (input valid, frame_ready, raw_x, raw_y, scaled_x, scaled_y, button_bits,
                  output ready);
endinterface

interface tecs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tecs_pkg::CfgIdxWidth-1:0] index;
  logic [tecs_pkg::SizeWidth-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/tablet_event_calibrate_scale.sv
// Tablet event calibration and scaling, top level.
// Event word: taken at once; the input is ready again the next cycle.
// Read word with a frame pending: busy until pushed; the shared scale unit runs
// X then Y, each pass ending in 16 restoring-divide steps.
// Read word with no frame pending: busy only until pushed. Results wait in an output register.
// Reset (async, active low) clears position, min/max, buttons, flags; sizes go to 1024x768.
`default_nettype none

module tablet_event_calibrate_scale (
  input  logic        clk_i,
  input  logic        rst_ni,
  tecs_evt_if.sink    evt_i,
  tecs_cfg_if.sink    cfg_i,
  tecs_res_if.source  res_o
);

  tecs_pkg::seq_state_e state_q, state_d;

  tecs_pkg::size_t      width_q, height_q;
  tecs_pkg::trk_state_t trk;
  tecs_pkg::result_t    res_q;
  tecs_pkg::result_t    out_q;
  logic                 out_valid_q;

  logic                 evt_fire, ev_fire, rd_fire, consume;
  logic                 scl_start, scl_done, push;
  tecs_pkg::scale_req_t scl_req;
  tecs_pkg::size_t      scl_quot;

  // Config writes land at once; the port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tecs_pkg::ResetScreenWidth;
      height_q <= tecs_pkg::ResetScreenHeight;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tecs_pkg::CfgScreenWidth:  width_q  <= cfg_i.data;
        tecs_pkg::CfgScreenHeight: height_q <= cfg_i.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Input word handshake: only the idle sequencer takes a word.
  assign evt_i.ready = (state_q == tecs_pkg::SeqIdle);
  assign evt_fire    = evt_i.valid & evt_i.ready;
  assign ev_fire     = evt_fire & (evt_i.req_type == tecs_pkg::ReqEvent);
  assign rd_fire     = evt_fire & (evt_i.req_type == tecs_pkg::ReqRead);
  // A read with a frame pending consumes the flag right away.
  assign consume     = rd_fire & trk.pending;

  tecs_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_fire_i  (ev_fire),
    .ev_type_i  (evt_i.ev_type),
    .ev_code_i  (evt_i.ev_code),
    .ev_value_i (evt_i.ev_value),
    .consume_i  (consume),
    .trk_o      (trk)
  );

  tecs_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scl_start),
    .req_i   (scl_req),
    .done_o  (scl_done),
    .quot_o  (scl_quot)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tecs_pkg::SeqIdle: begin
        if (rd_fire) state_d = trk.pending ? tecs_pkg::SeqXStart : tecs_pkg::SeqPush;
      end
      tecs_pkg::SeqXStart: state_d = tecs_pkg::SeqXWait;
      tecs_pkg::SeqXWait:  if (scl_done) state_d = tecs_pkg::SeqYStart;
      tecs_pkg::SeqYStart: state_d = tecs_pkg::SeqYWait;
      tecs_pkg::SeqYWait:  if (scl_done) state_d = tecs_pkg::SeqPush;
      tecs_pkg::SeqPush:   if (!out_valid_q || res_o.ready) state_d = tecs_pkg::SeqIdle;
      default:             state_d = tecs_pkg::SeqIdle;
    endcase
  end

  // Sequencer outputs: kick the scale unit and pick which axis feeds it.
  // Tracker state holds still while busy, since no word is taken.
  always_comb begin
    scl_start = 1'b0;
    push      = 1'b0;
    scl_req   = '{pos: trk.cur_x, lo: trk.min_x, hi: trk.max_x, size: width_q};
    unique case (state_q)
      tecs_pkg::SeqXStart: scl_start = 1'b1;
      tecs_pkg::SeqYStart: begin
        scl_start = 1'b1;
        scl_req   = '{pos: trk.cur_y, lo: trk.min_y, hi: trk.max_y, size: height_q};
      end
      tecs_pkg::SeqPush:   push = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tecs_pkg::SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Build the result word: raw fields at accept, scaled fields as each pass ends.
  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      if (trk.pending) begin
        res_q.frame_ready <= 1'b1;
        res_q.raw_x       <= tecs_pkg::ValueWidth'($signed(trk.cur_x));
        res_q.raw_y       <= tecs_pkg::ValueWidth'($signed(trk.cur_y));
        res_q.scaled_x    <= '0;
        res_q.scaled_y    <= '0;
        res_q.button_bits <= trk.pressed;
      end else begin
        res_q <= '0;
      end
    end else if (scl_done && (state_q == tecs_pkg::SeqXWait)) begin
      res_q.scaled_x <= scl_quot;
    end else if (scl_done && (state_q == tecs_pkg::SeqYWait)) begin
      res_q.scaled_y <= scl_quot;
    end
  end

  // Output register: hold the word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) out_q <= res_q;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.frame_ready = out_q.frame_ready;
  assign res_o.raw_x       = out_q.raw_x;
  assign res_o.raw_y       = out_q.raw_y;
  assign res_o.scaled_x    = out_q.scaled_x;
  assign res_o.scaled_y    = out_q.scaled_y;
  assign res_o.button_bits = out_q.button_bits;

endmodule

`default_nettype wire

>>> src/tecs_track.sv
// Position, min/max calibration, button and frame-pending state.
// Depends on tecs_pkg.
`default_nettype none

module tecs_track (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               ev_fire_i,
  input  logic [tecs_pkg::TypeWidth-1:0]     ev_type_i,
  input  logic [tecs_pkg::CodeWidth-1:0]     ev_code_i,
  input  logic signed [tecs_pkg::ValueWidth-1:0] ev_value_i,
  input  logic                               consume_i,
  output tecs_pkg::trk_state_t               trk_o
);

  tecs_pkg::coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  tecs_pkg::coord_t min_x_q, min_x_d, max_x_q, max_x_d;
  tecs_pkg::coord_t min_y_q, min_y_d, max_y_q, max_y_d;
  tecs_pkg::btn_t   pressed_q, pressed_d;
  logic             pending_q, pending_d;
  logic             calib_q, calib_d;
  tecs_pkg::coord_t sample;
  logic             key_on;

  // Keep the low coordinate bits and treat them as signed.
  assign sample = tecs_pkg::coord_t'(ev_value_i[tecs_pkg::CoordWidth-1:0]);
  assign key_on = (ev_value_i != '0);

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    min_x_d   = min_x_q;
    max_x_d   = max_x_q;
    min_y_d   = min_y_q;
    max_y_d   = max_y_q;
    pressed_d = pressed_q;
    pending_d = pending_q;
    calib_d   = calib_q;
    if (ev_fire_i) begin
      unique case (ev_type_i)
        tecs_pkg::EvtAbs: begin
          if (ev_code_i == tecs_pkg::AxisX) begin
            cur_x_d = sample;
            if (!calib_q) begin
              min_x_d = sample;
              max_x_d = sample;
            end else begin
              if (sample < min_x_q) min_x_d = sample;
              if (sample > max_x_q) max_x_d = sample;
            end
          end else if (ev_code_i == tecs_pkg::AxisY) begin
            cur_y_d = sample;
            if (!calib_q) begin
              min_y_d = sample;
              max_y_d = sample;
            end else begin
              if (sample < min_y_q) min_y_d = sample;
              if (sample > max_y_q) max_y_d = sample;
            end
          end
        end
        tecs_pkg::EvtKey: begin
          if (ev_code_i == tecs_pkg::KeyLeft) begin
            pressed_d = key_on ? (pressed_q | tecs_pkg::BtnLeft) : (pressed_q & ~tecs_pkg::BtnLeft);
          end else if (ev_code_i == tecs_pkg::KeyRight) begin
            pressed_d = key_on ? (pressed_q | tecs_pkg::BtnRight) : (pressed_q & ~tecs_pkg::BtnRight);
          end else if (ev_code_i == tecs_pkg::KeyMiddle) begin
            pressed_d = key_on ? (pressed_q | tecs_pkg::BtnMiddle)
                               : (pressed_q & ~tecs_pkg::BtnMiddle);
          end
        end
        tecs_pkg::EvtSyn: begin
          if (ev_code_i == tecs_pkg::SyncReport) begin
            pending_d = 1'b1;
            calib_d   = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (consume_i) pending_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      min_x_q   <= '0;
      max_x_q   <= '0;
      min_y_q   <= '0;
      max_y_q   <= '0;
      pressed_q <= '0;
      pending_q <= 1'b0;
      calib_q   <= 1'b0;
    end else begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      min_x_q   <= min_x_d;
      max_x_q   <= max_x_d;
      min_y_q   <= min_y_d;
      max_y_q   <= max_y_d;
      pressed_q <= pressed_d;
      pending_q <= pending_d;
      calib_q   <= calib_d;
    end
  end

  always_comb begin
    trk_o.cur_x   = cur_x_q;
    trk_o.cur_y   = cur_y_q;
    trk_o.min_x   = min_x_q;
    trk_o.max_x   = max_x_q;
    trk_o.min_y   = min_y_q;
    trk_o.max_y   = max_y_q;
    trk_o.pressed = pressed_q;
    trk_o.pending = pending_q;
  end

endmodule

`default_nettype wire

>>> src/tecs_scale.sv
// Shared scaling unit: range/offset clamp, one multiply, then a restoring
// divider that retires one quotient bit per cycle. Depends on tecs_pkg.
`default_nettype none

module tecs_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  tecs_pkg::scale_req_t   req_i,
  output logic                   done_o,
  output tecs_pkg::size_t        quot_o
);

  localparam int unsigned CW = tecs_pkg::CoordWidth;
  localparam int unsigned SW = tecs_pkg::SizeWidth;
  localparam int unsigned RW = tecs_pkg::RangeWidth;
  localparam int unsigned PW = tecs_pkg::ProdWidth;
  localparam int unsigned NW = tecs_pkg::DivCntWidth;

  tecs_pkg::scale_state_e state_q, state_d;

  tecs_pkg::coord_t pos_q, lo_q, hi_q;
  tecs_pkg::size_t  factor_q;
  logic [CW-1:0]    range_q;
  tecs_pkg::span_t  off_raw_q;
  logic [CW-1:0]    off_q;
  logic [CW-1:0]    rem_q;
  logic [SW-1:0]    shf_q;
  logic [NW-1:0]    cnt_q;

  tecs_pkg::span_t  span_pos, span_lo, span_hi, range_full, off_full;
  logic [CW-1:0]    range_pos, off_clamp;
  logic [PW-1:0]    prod;
  logic [CW:0]      trial, trial_diff;
  logic             trial_ge;

  // Range and offset at 33 bits; a non-positive range becomes one.
  assign span_pos   = tecs_pkg::span_t'(pos_q);
  assign span_lo    = tecs_pkg::span_t'(lo_q);
  assign span_hi    = tecs_pkg::span_t'(hi_q);
  assign range_full = span_hi - span_lo;
  assign off_full   = span_pos - span_lo;
  assign range_pos  = (!range_full[RW-1] && (range_full != '0)) ? range_full[CW-1:0]
                                                                   : CW'(1);

  // Clamp the offset into 0..range.
  assign off_clamp = off_raw_q[RW-1] ? '0 :
                     ((off_raw_q[CW-1:0] > range_q) ? range_q : off_raw_q[CW-1:0]);

  assign prod = PW'(off_q) * PW'(factor_q);

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign trial      = {rem_q, shf_q[SW-1]};
  assign trial_ge   = (trial >= {1'b0, range_q});
  assign trial_diff = trial - {1'b0, range_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tecs_pkg::ScIdle:   if (start_i) state_d = tecs_pkg::ScRange;
      tecs_pkg::ScRange:  state_d = tecs_pkg::ScOffset;
      tecs_pkg::ScOffset: state_d = tecs_pkg::ScMul;
      tecs_pkg::ScMul:    state_d = tecs_pkg::ScDiv;
      tecs_pkg::ScDiv:    if (cnt_q == NW'(SW - 1)) state_d = tecs_pkg::ScDone;
      tecs_pkg::ScDone:   state_d = tecs_pkg::ScIdle;
      default:            state_d = tecs_pkg::ScIdle;
    endcase
  end

  always_comb begin
    done_o = (state_q == tecs_pkg::ScDone);
    quot_o = shf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tecs_pkg::ScIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == tecs_pkg::ScDiv) begin
        cnt_q <= cnt_q + NW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tecs_pkg::ScIdle: begin
        if (start_i) begin
          pos_q    <= req_i.pos;
          lo_q     <= req_i.lo;
          hi_q     <= req_i.hi;
          factor_q <= (req_i.size == '0) ? '0 : (req_i.size - SW'(1));
        end
      end
      tecs_pkg::ScRange: begin
        range_q   <= range_pos;
        off_raw_q <= off_full;
      end
      tecs_pkg::ScOffset: begin
        off_q <= off_clamp;
      end
      tecs_pkg::ScMul: begin
        // Quotient fits SW bits since offset <= range, so the upper part
        // already sits below the divisor.
        rem_q <= prod[PW-1:SW];
        shf_q <= prod[SW-1:0];
      end
      tecs_pkg::ScDiv: begin
        rem_q <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
        shf_q <= {shf_q[SW-2:0], trial_ge};
      end
      tecs_pkg::ScDone: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/tecs_checker.sv
// Port-level checks for the tablet calibrate/scale top, attached by bind.
// Depends on tecs_pkg and tablet_event_calibrate_scale.
`default_nettype none

module tecs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              evt_valid,
  input logic                              evt_ready,
  input logic                              evt_req_type,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic                              res_frame_ready,
  input logic [tecs_pkg::ValueWidth-1:0]   res_raw_x,
  input logic [tecs_pkg::ValueWidth-1:0]   res_raw_y,
  input logic [tecs_pkg::SizeWidth-1:0]    res_scaled_x,
  input logic [tecs_pkg::SizeWidth-1:0]    res_scaled_y,
  input logic [tecs_pkg::BtnWidth-1:0]     res_button_bits
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_frame_ready) && $stable(res_raw_x)
                                && $stable(res_scaled_x) && $stable(res_scaled_y))
    else $error("result word changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_frame_ready |-> res_raw_x == '0 && res_raw_y == '0
                                      && res_scaled_x == '0 && res_scaled_y == '0
                                      && res_button_bits == '0)
    else $error("empty read carries nonzero fields");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && evt_ready && (evt_req_type == tecs_pkg::ReqRead) |=> !evt_ready)
    else $error("read word did not occupy the block");

  a_event_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid && evt_ready && (evt_req_type == tecs_pkg::ReqEvent) |=> evt_ready)
    else $error("event word stalled the input");

endmodule

bind tablet_event_calibrate_scale tecs_checker u_tecs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .evt_valid       (evt_i.valid),
  .evt_ready       (evt_i.ready),
  .evt_req_type    (evt_i.req_type),
  .res_valid       (res_o.valid),
  .res_ready       (res_o.ready),
  .res_frame_ready (res_o.frame_ready),
  .res_raw_x       (res_o.raw_x),
  .res_raw_y       (res_o.raw_y),
  .res_scaled_x    (res_o.scaled_x),
  .res_scaled_y    (res_o.scaled_y),
  .res_button_bits (res_o.button_bits)
);

`default_nettype wire
